// ===== design/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and controller/datapath interface types for the lattice
// line path stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int DefMaxOffset = 16;
  localparam int ResultLimit  = 48;
  localparam int OffW         = 6;
  localparam int AxisW        = 2;
  localparam int IdxW         = $clog2(ResultLimit);
  localparam int CntW         = $clog2(ResultLimit + 1);

  localparam logic [AxisW-1:0] AXIS_X = 2'd0;
  localparam logic [AxisW-1:0] AXIS_Y = 2'd1;
  localparam logic [AxisW-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } lps_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } lps_status_t;

endpackage

// ===== design/lattice_line_path_stepper.sv =====
// ----------------------------------------------------------------------------
// lattice_line_path_stepper
// Emits the unit-step lattice path that stays closest to the line from the
// origin toward |offset|, one axis step per output transfer.
// ----------------------------------------------------------------------------
// An offset of N = |x|+|y|+|z| steps (magnitudes saturated to MAX_OFFSET,
// at most 48 steps emitted) passes through the block in order: the load
// latches the magnitudes, the init state forms the products and seeds the
// three score accumulators, then the accumulator update issues one step
// per cycle while the output side does not stall. The input is stalled
// from accept until the last step has been issued; an all-zero offset
// produces no transfer and frees the input after init. The last step
// carries last_step, and end_mismatch if the walk did not reach the target.
module lattice_line_path_stepper
  import lps_pkg::*;
#(
  parameter int MAX_OFFSET = DefMaxOffset
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [OffW-1:0] offset_x_i,
  input  logic signed [OffW-1:0] offset_y_i,
  input  logic signed [OffW-1:0] offset_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [AxisW-1:0]       axis_o,
  output logic [IdxW-1:0]        step_index_o,
  output logic                   last_step_o,
  output logic                   end_mismatch_o
);

  lps_cmd_t    cmd;
  lps_status_t status;

  lps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lps_datapath #(
    .MaxOffset (MAX_OFFSET)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .offset_x_i     (offset_x_i),
    .offset_y_i     (offset_y_i),
    .offset_z_i     (offset_z_i),
    .axis_o         (axis_o),
    .step_index_o   (step_index_o),
    .last_step_o    (last_step_o),
    .end_mismatch_o (end_mismatch_o)
  );

endmodule

// ===== design/lps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer: takes one offset, runs the setup cycles, then issues one step
// command per free output slot until the path ends. Owns the output valid.
// ----------------------------------------------------------------------------
module lps_ctrl
  import lps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lps_cmd_t    cmd_o,
  input  lps_status_t status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = status_i.empty ? ST_IDLE : ST_STEP;
      end
      ST_STEP: begin
        if (slot_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.step | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.init, cmd_o.step}))
    else $error("more than one datapath command");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && status_i.last |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last step");

  a_step_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP && !out_valid_q |-> cmd_o.step)
    else $error("free output slot not used while stepping");

endmodule

// ===== design/lps_datapath.sv =====
// ----------------------------------------------------------------------------
// lps_datapath
// Target magnitudes, per-axis score accumulators and the output register.
// Scores are kept as differences from the common term, so each step is
// only adds and a three-way compare.
// ----------------------------------------------------------------------------
module lps_datapath
  import lps_pkg::*;
#(
  parameter int MaxOffset = DefMaxOffset
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lps_cmd_t               cmd_i,
  output lps_status_t            status_o,
  input  logic signed [OffW-1:0] offset_x_i,
  input  logic signed [OffW-1:0] offset_y_i,
  input  logic signed [OffW-1:0] offset_z_i,
  output logic [AxisW-1:0]       axis_o,
  output logic [IdxW-1:0]        step_index_o,
  output logic                   last_step_o,
  output logic                   end_mismatch_o
);

  localparam int MagW = $clog2(MaxOffset + 1);
  localparam int SqW  = 2 * MagW;
  localparam int CcW  = SqW + 2;
  localparam int ScW  = SqW + 10;
  localparam int TotW = MagW + 2;

  function automatic logic [MagW-1:0] sat_mag(input logic signed [OffW-1:0] raw);
    logic signed [OffW:0] ext;
    logic [OffW:0]        mag;
    ext = {raw[OffW-1], raw};
    mag = ext[OffW] ? -ext : ext;
    if (32'(mag) > MaxOffset) sat_mag = MagW'(MaxOffset);
    else                      sat_mag = MagW'(mag);
  endfunction

  logic [MagW-1:0]        mag_d [3];
  logic [TotW-1:0]        total_d;
  logic [MagW-1:0]        tgt_q [3];
  logic                   trunc_q;
  logic [CntW-1:0]        emit_q;

  logic [SqW-1:0]         prod_d [3][3];
  logic [SqW-1:0]         prod_q [3][3];
  logic [CcW-1:0]         cc_d, cc_q;
  logic signed [ScW-1:0]  d_q [3];
  logic signed [ScW-1:0]  d_init [3];
  logic signed [ScW-1:0]  d_next [3];
  logic [CntW-1:0]        pos_q [3];
  logic [CntW-1:0]        pos_next [3];
  logic [IdxW-1:0]        idx_q;

  logic [AxisW-1:0]       sel;
  logic [SqW-1:0]         row [3];
  logic                   mismatch;

  logic [AxisW-1:0]       axis_q;
  logic [IdxW-1:0]        sidx_q;
  logic                   last_q;
  logic                   mis_q;

  always_comb begin
    mag_d[0] = sat_mag(offset_x_i);
    mag_d[1] = sat_mag(offset_y_i);
    mag_d[2] = sat_mag(offset_z_i);
    total_d  = TotW'(mag_d[0]) + TotW'(mag_d[1]) + TotW'(mag_d[2]);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[j][k] = SqW'(tgt_q[j]) * SqW'(tgt_q[k]);
      end
    end
    cc_d = CcW'(prod_d[0][0]) + CcW'(prod_d[1][1]) + CcW'(prod_d[2][2]);
    for (int k = 0; k < 3; k++) begin
      d_init[k] = signed'(ScW'(cc_d)) - signed'(ScW'(prod_d[k][k]));
    end
  end

  // Tie order: x, then y.
  always_comb begin
    if (d_q[0] <= d_q[1] && d_q[0] <= d_q[2])     sel = AXIS_X;
    else if (d_q[1] < d_q[0] && d_q[1] <= d_q[2]) sel = AXIS_Y;
    else                                          sel = AXIS_Z;
  end

  always_comb begin
    case (sel)
      AXIS_X:  row = prod_q[0];
      AXIS_Y:  row = prod_q[1];
      default: row = prod_q[2];
    endcase
  end

  always_comb begin
    mismatch = trunc_q;
    for (int k = 0; k < 3; k++) begin
      d_next[k] = d_q[k] - signed'(ScW'({row[k], 1'b0}));
      if (sel == AxisW'(k)) begin
        d_next[k]   = d_next[k] + signed'(ScW'({cc_q, 1'b0}));
        pos_next[k] = pos_q[k] + CntW'(1);
      end else begin
        pos_next[k] = pos_q[k];
      end
      if (32'(pos_next[k]) != 32'(tgt_q[k])) mismatch = 1'b1;
    end
  end

  assign status_o.empty = (emit_q == '0);
  assign status_o.last  = ((CntW'(idx_q) + CntW'(1)) == emit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q   <= mag_d;
      trunc_q <= 32'(total_d) > ResultLimit;
      emit_q  <= (32'(total_d) > ResultLimit) ? CntW'(ResultLimit) : CntW'(total_d);
    end
    if (cmd_i.init) begin
      prod_q <= prod_d;
      cc_q   <= cc_d;
      d_q    <= d_init;
      for (int k = 0; k < 3; k++) pos_q[k] <= '0;
      idx_q  <= '0;
    end
    if (cmd_i.step) begin
      d_q    <= d_next;
      pos_q  <= pos_next;
      idx_q  <= idx_q + IdxW'(1);
      axis_q <= sel;
      sidx_q <= idx_q;
      last_q <= status_o.last;
      mis_q  <= status_o.last & mismatch;
    end
  end

  assign axis_o         = axis_q;
  assign step_index_o   = sidx_q;
  assign last_step_o    = last_q;
  assign end_mismatch_o = mis_q;

  a_pos_tracks_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> 32'(pos_q[0]) + 32'(pos_q[1]) + 32'(pos_q[2]) == 32'(idx_q))
    else $error("position sum out of step with step index");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> CntW'(idx_q) < emit_q)
    else $error("step issued beyond path length");

endmodule

// ===== sim/lattice_line_path_stepper_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_line_path_stepper_test
// Self-checking bench for the lattice line path stepper. A queue of offsets
// (directed corners, then random ones) feeds a clocked driver. Each accepted
// offset is walked by a local path predictor, and a clocked monitor checks
// every output step against the oldest predicted step. Both sides idle at
// random, and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module lattice_line_path_stepper_test;
  import lps_pkg::*;

  localparam int MaxOffset   = DefMaxOffset;
  localparam int RandomItems = 205;
  localparam int HoldStart   = 300;
  localparam int HoldLen     = 250;
  localparam int DrainCycles = ResultLimit + 12;

  typedef struct packed {
    logic signed [OffW-1:0] x;
    logic signed [OffW-1:0] y;
    logic signed [OffW-1:0] z;
  } offset_t;

  typedef struct packed {
    logic [AxisW-1:0] axis;
    logic [IdxW-1:0]  idx;
    logic             last;
    logic             mism;
  } path_step_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic signed [OffW-1:0] offset_x_i  = '0;
  logic signed [OffW-1:0] offset_y_i  = '0;
  logic signed [OffW-1:0] offset_z_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [AxisW-1:0]       axis_o;
  logic [IdxW-1:0]        step_index_o;
  logic                   last_step_o;
  logic                   end_mismatch_o;

  offset_t    pending_offsets[$];
  path_step_t expected_steps[$];

  int  errors        = 0;
  int  offsets_sent  = 0;
  int  zero_offsets  = 0;
  int  steps_checked = 0;
  int  miss_flags    = 0;
  int  in_wait       = 0;
  int  out_wait      = 0;
  bit  in_calm       = 1'b0;
  bit  out_calm      = 1'b0;
  int  cycle_count   = 0;
  logic hold_off     = 1'b0;

  lattice_line_path_stepper #(
    .MAX_OFFSET(MaxOffset)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .offset_z_i    (offset_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axis_o        (axis_o),
    .step_index_o  (step_index_o),
    .last_step_o   (last_step_o),
    .end_mismatch_o(end_mismatch_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int sat_magnitude(input logic signed [OffW-1:0] v);
    int m;
    m = int'(v);
    if (m < 0) m = -m;
    if (m > MaxOffset) m = MaxOffset;
    return m;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic logic [OffW-1:0] rand_component();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return OffW'($urandom_range(0, 63));
    return OffW'(int'($urandom_range(0, 32)) - 16);
  endfunction

  // Greedy walk toward |offset|; one expected step per emitted transfer.
  task automatic predict_path(input offset_t o);
    int tgt[3];
    int pos[3];
    int cand[3];
    longint score[3];
    longint cc;
    longint qc;
    int total;
    int emit;
    int ax;
    path_step_t s;
    tgt[0] = sat_magnitude(o.x);
    tgt[1] = sat_magnitude(o.y);
    tgt[2] = sat_magnitude(o.z);
    pos = '{0, 0, 0};
    cc = tgt[0] * tgt[0] + tgt[1] * tgt[1] + tgt[2] * tgt[2];
    total = tgt[0] + tgt[1] + tgt[2];
    emit = (total > ResultLimit) ? ResultLimit : total;
    if (emit == 0) zero_offsets++;
    for (int i = 0; i < emit; i++) begin
      for (int k = 0; k < 3; k++) begin
        cand = pos;
        cand[k] += 1;
        qc = cand[0] * tgt[0] + cand[1] * tgt[1] + cand[2] * tgt[2];
        score[k] = (cand[0] * cand[0] + cand[1] * cand[1] + cand[2] * cand[2]) * cc
                   - qc * qc;
      end
      if (score[0] <= score[1] && score[0] <= score[2]) s.axis = AXIS_X;
      else if (score[1] < score[0] && score[1] <= score[2]) s.axis = AXIS_Y;
      else s.axis = AXIS_Z;
      ax = int'(s.axis);
      pos[ax] += 1;
      s.idx  = IdxW'(i);
      s.last = (i == emit - 1);
      s.mism = s.last && ((emit != total) || pos[0] != tgt[0] ||
                          pos[1] != tgt[1] || pos[2] != tgt[2]);
      expected_steps.push_back(s);
    end
  endtask

  task automatic present_next();
    offset_t o;
    o = pending_offsets.pop_front();
    offset_x_i <= o.x;
    offset_y_i <= o.y;
    offset_z_i <= o.z;
    in_valid_i <= 1'b1;
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_path('{offset_x_i, offset_y_i, offset_z_i});
        offsets_sent++;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        in_wait = draw_wait(in_calm);
        if (in_wait == 0 && pending_offsets.size() > 0) present_next();
        else in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (in_wait > 0) in_wait--;
        else if (pending_offsets.size() > 0) present_next();
      end
    end
  end

  // Long output hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      hold_off    <= (cycle_count >= HoldStart) && (cycle_count < HoldStart + HoldLen);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    path_step_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual axis %0d step %0d",
                   $time, axis_o, step_index_o);
          errors++;
        end else begin
          e = expected_steps.pop_front();
          compare_field("axis", e.axis, axis_o);
          compare_field("step_index", e.idx, step_index_o);
          compare_field("last_step", e.last, last_step_o);
          compare_field("end_mismatch", e.mism, end_mismatch_o);
          if (end_mismatch_o) miss_flags++;
          steps_checked++;
        end
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_wait = draw_wait(out_calm);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall_i <= hold_off || (out_wait != 0);
    end
  end

  initial begin
    offset_t o;
    offset_t directed[$];
    directed = '{
      '{6'sd0, 6'sd0, 6'sd0},     '{6'sd16, 6'sd16, 6'sd16},
      '{-6'sd16, -6'sd16, -6'sd16}, '{-6'sd32, -6'sd32, -6'sd32},
      '{6'sd31, 6'sd31, 6'sd31},  '{6'sd1, 6'sd0, 6'sd0},
      '{6'sd0, 6'sd1, 6'sd0},     '{6'sd0, 6'sd0, 6'sd1},
      '{-6'sd1, 6'sd0, 6'sd0},    '{6'sd1, 6'sd1, 6'sd0},
      '{6'sd1, 6'sd1, 6'sd1},     '{6'sd0, 6'sd1, 6'sd1},
      '{6'sd1, 6'sd0, 6'sd1},     '{6'sd17, 6'sd0, 6'sd0},
      '{-6'sd17, 6'sd5, -6'sd3},  '{6'sd3, 6'sd5, 6'sd7},
      '{-6'sd32, 6'sd0, 6'sd0},   '{6'sd0, -6'sd32, 6'sd31},
      '{6'sd2, 6'sd2, 6'sd1},     '{6'sd5, -6'sd5, 6'sd5},
      '{6'sd0, 6'sd0, 6'sd0},     '{6'sd16, 6'sd0, 6'sd0},
      '{6'sd0, 6'sd16, 6'sd0},    '{6'sd0, 6'sd0, 6'sd16},
      '{-6'sd20, 6'sd12, -6'sd9}
    };
    foreach (directed[i]) pending_offsets.push_back(directed[i]);
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        o = '0;
      end else begin
        o.x = rand_component();
        o.y = rand_component();
        o.z = rand_component();
      end
      pending_offsets.push_back(o);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_offsets.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_steps.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d offsets (%0d with an empty path) and %0d path steps,",
             offsets_sent, zero_offsets, steps_checked);
    $display("%0d endpoint miss flags, with random idling and one long output hold-off.",
             miss_flags);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d steps outstanding", $time, expected_steps.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
